>>> rtl/sactl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_pkg
// Shared constants, types and helpers of the set-associative tag lookup.
// ----------------------------------------------------------------------------
package sactl_pkg;

  localparam int unsigned MAX_SETS   = 1024;
  localparam int unsigned MAX_WAYS   = 16;
  localparam int unsigned ADDR_BITS  = 32;

  localparam int unsigned OFF_MAX    = 12;
  localparam int unsigned IDX_MAX    = 10;
  localparam int unsigned OFF_W      = 4;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned WAYS_CFG_W = 5;
  localparam int unsigned WAY_OUT_W  = 4;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned LFSR_W     = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [OFF_W-1:0]      OFF_RST    = 4'd4;
  localparam logic [IDX_W-1:0]      IDX_RST    = 4'd6;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RST   = 5'd2;
  localparam logic                  POLICY_RST = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET = 8'd0,
    REG_INDEX  = 8'd1,
    REG_WAYS   = 8'd2,
    REG_POLICY = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_HIT        = 2'd0,
    KIND_COMPULSORY = 2'd1,
    KIND_CONFLICT   = 2'd2
  } miss_kind_e;

  typedef struct packed {
    logic [OFF_W-1:0]      offset_bits;
    logic [IDX_W-1:0]      index_bits;
    logic [WAYS_CFG_W-1:0] ways_in_use;
    logic                  random_policy;
  } cfg_t;

  // taps 16,14,13,11, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic b;
    b = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {b, v[LFSR_W-1:1]};
  endfunction

endpackage

>>> rtl/sactl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl interfaces
// Access, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface sactl_req_if #(
  parameter int unsigned ADDR_BITS = sactl_pkg::ADDR_BITS
);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sactl_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [1:0]                          miss_kind;
  logic [sactl_pkg::WAY_OUT_W-1:0]     way_used;
  logic [sactl_pkg::CNT_W-1:0]         access_count;
  logic [sactl_pkg::CNT_W-1:0]         hit_count;
  logic [sactl_pkg::CNT_W-1:0]         compulsory_count;
  logic [sactl_pkg::CNT_W-1:0]         conflict_count;
  modport source (output valid, output hit, output miss_kind, output way_used,
                  output access_count, output hit_count, output compulsory_count,
                  output conflict_count, input ready);
  modport sink   (input valid, input hit, input miss_kind, input way_used,
                  input access_count, input hit_count, input compulsory_count,
                  input conflict_count, output ready);
endinterface

interface sactl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sactl_pkg::CFG_IDX_W-1:0]  index;
  logic [sactl_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sactl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_front
// Takes access words, derives the block tag and the set number.
// ----------------------------------------------------------------------------
module sactl_front #(
  parameter int unsigned ADDR_BITS = sactl_pkg::ADDR_BITS,
  parameter int unsigned MAX_SETS  = sactl_pkg::MAX_SETS,
  localparam int unsigned SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  sactl_req_if.sink             req,
  input  sactl_pkg::cfg_t       cfg_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output logic [ADDR_BITS-1:0]  tag_o,
  output logic [SET_W-1:0]      set_o
);

  localparam int unsigned IDX_MAX = sactl_pkg::IDX_MAX;
  localparam int unsigned R_W     = IDX_MAX + 1;
  localparam int unsigned RS      = 21;
  localparam int unsigned PROD_W  = IDX_MAX + RS + 1;
  localparam longint unsigned RECIP = ((64'd1 << RS) + MAX_SETS - 1) / MAX_SETS;

  logic [sactl_pkg::OFF_W-1:0] off_eff;
  logic [sactl_pkg::IDX_W-1:0] idx_eff;
  logic [IDX_MAX-1:0]          masked;
  logic [R_W-1:0]              rem;
  logic [PROD_W-1:0]           prod;
  logic [IDX_MAX-1:0]          quo;

  assign req.ready = !q_full_i;
  assign push_o    = req.valid && !q_full_i;

  always_comb begin
    off_eff = (cfg_i.offset_bits > sactl_pkg::OFF_W'(sactl_pkg::OFF_MAX)) ?
              sactl_pkg::OFF_W'(sactl_pkg::OFF_MAX) : cfg_i.offset_bits;
    idx_eff = (cfg_i.index_bits > sactl_pkg::IDX_W'(IDX_MAX)) ?
              sactl_pkg::IDX_W'(IDX_MAX) : cfg_i.index_bits;
  end

  assign tag_o = req.address >> off_eff;

  always_comb begin
    for (int i = 0; i < IDX_MAX; i++) begin
      masked[i] = tag_o[i] && (sactl_pkg::IDX_W'(i) < idx_eff);
    end
  end

  // set number folded into the sets present; quotient by reciprocal multiply
  always_comb begin
    prod = PROD_W'(masked) * PROD_W'(RECIP);
    quo  = prod[RS +: IDX_MAX];
    if (MAX_SETS < (2 ** IDX_MAX)) begin
      rem = R_W'(masked) - R_W'(PROD_W'(quo) * PROD_W'(MAX_SETS));
    end else begin
      rem = R_W'(masked);
    end
  end

  assign set_o = SET_W'(rem);

endmodule

>>> rtl/sactl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module sactl_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/sactl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_back
// Reads the set, compares tags, picks the victim, fills it, keeps counts.
// ----------------------------------------------------------------------------
module sactl_back #(
  parameter int unsigned ADDR_BITS = sactl_pkg::ADDR_BITS,
  parameter int unsigned MAX_SETS  = sactl_pkg::MAX_SETS,
  parameter int unsigned MAX_WAYS  = sactl_pkg::MAX_WAYS,
  localparam int unsigned SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sactl_pkg::cfg_t      cfg_i,
  input  logic                 q_valid_i,
  input  logic [ADDR_BITS-1:0] q_tag_i,
  input  logic [SET_W-1:0]     q_set_i,
  output logic                 pop_o,
  sactl_rsp_if.source          rsp
);

  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WAYS_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned REM_W  = WAYS_W + 1;
  localparam int unsigned LFSR_W = sactl_pkg::LFSR_W;
  localparam int unsigned CHUNK  = 4;
  localparam int unsigned STEPS  = LFSR_W / CHUNK;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam int unsigned CNT_W  = sactl_pkg::CNT_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_MOD   = 5'b01000,
    ST_UPD   = 5'b10000
  } state_e;

  logic [MAX_WAYS-1:0]                valid_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem   [MAX_SETS];
  logic [WAY_W-1:0]                   rr_mem    [MAX_SETS];

  logic [MAX_WAYS-1:0]                valid_rd_q;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_rd_q;
  logic [WAY_W-1:0]                   rr_rd_q;

  state_e               state_q, state_d;
  logic [SET_W-1:0]     clr_q, clr_d;
  logic [ADDR_BITS-1:0] cur_tag_q;
  logic [SET_W-1:0]     cur_set_q;
  logic                 hit_q, hit_d;
  logic [1:0]           kind_q, kind_d;
  logic [WAY_W-1:0]     way_q, way_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [LFSR_W-1:0]    src_q, src_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [LFSR_W-1:0]    lfsr_q, lfsr_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q;
  logic [1:0]           out_kind_q;
  logic [WAY_W-1:0]     out_way_q;
  logic [CNT_W-1:0]     acc_q, hits_q, comp_q, conf_q;

  logic [WAYS_W-1:0]    ways_eff;
  logic [MAX_WAYS-1:0]  match, invalid;
  logic [WAY_W-1:0]     hit_way, rr_victim, nxt_ptr;
  logic [REM_W-1:0]     rem_step;
  logic                 rd_en, fire, upd;
  logic                 mem_we, tag_we;
  logic [SET_W-1:0]     wa;
  logic [MAX_WAYS-1:0]  wvalid;
  logic [WAY_W-1:0]     wrr;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] wtag;

  always_comb begin
    if (cfg_i.ways_in_use == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (cfg_i.ways_in_use > sactl_pkg::WAYS_CFG_W'(MAX_WAYS)) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYS_W'(cfg_i.ways_in_use);
    end
  end

  // tag compare over the ways in use, lowest match wins
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w]   = valid_rd_q[w] && (tag_rd_q[w] == cur_tag_q) &&
                   (WAYS_W'(w) < ways_eff);
      invalid[w] = !valid_rd_q[w] && (WAYS_W'(w) < ways_eff);
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
    end
    rr_victim = (WAYS_W'(rr_rd_q) >= ways_eff) ? '0 : rr_rd_q;
  end

  // four remainder bits a cycle, LFSR word taken MSB first
  always_comb begin
    rem_step = rem_q;
    for (int b = 0; b < CHUNK; b++) begin
      rem_step = {rem_step[REM_W-2:0], src_q[LFSR_W-1-b]};
      if (rem_step >= REM_W'(ways_eff)) rem_step = rem_step - REM_W'(ways_eff);
    end
  end

  assign fire    = !out_valid_q || rsp.ready;
  assign upd     = (state_q == ST_UPD) && fire;
  assign nxt_ptr = ((WAYS_W'(way_q) + WAYS_W'(1)) >= ways_eff) ? '0 : way_q + WAY_W'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    hit_d       = hit_q;
    kind_d      = kind_q;
    way_d       = way_q;
    rem_d       = rem_q;
    src_d       = src_q;
    step_d      = step_q;
    lfsr_d      = lfsr_q;
    rd_en       = 1'b0;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    tag_we      = 1'b0;
    wa          = cur_set_q;
    wvalid      = valid_rd_q;
    wrr         = nxt_ptr;
    wtag        = tag_rd_q;
    out_valid_d = out_valid_q && !rsp.ready;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        wa     = clr_q;
        wvalid = '0;
        wrr    = '0;
        clr_d  = clr_q + SET_W'(1);
        if (clr_q == SET_W'(MAX_SETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          rd_en   = 1'b1;
          pop_o   = 1'b1;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        hit_d = |match;
        if (|match) begin
          kind_d  = sactl_pkg::KIND_HIT;
          way_d   = hit_way;
          state_d = ST_UPD;
        end else begin
          kind_d = (|invalid) ? sactl_pkg::KIND_COMPULSORY : sactl_pkg::KIND_CONFLICT;
          if (cfg_i.random_policy) begin
            lfsr_d  = sactl_pkg::lfsr_next(lfsr_q);
            src_d   = sactl_pkg::lfsr_next(lfsr_q);
            rem_d   = '0;
            step_d  = '0;
            state_d = ST_MOD;
          end else begin
            way_d   = rr_victim;
            state_d = ST_UPD;
          end
        end
      end
      ST_MOD: begin
        rem_d  = rem_step;
        src_d  = src_q << CHUNK;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEPS - 1)) begin
          way_d   = WAY_W'(rem_step);
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (fire) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (!hit_q) begin
            mem_we         = 1'b1;
            tag_we         = 1'b1;
            wvalid[way_q]  = 1'b1;
            wtag[way_q]    = cur_tag_q;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      valid_mem[wa] <= wvalid;
      rr_mem[wa]    <= wrr;
    end
    if (tag_we) tag_mem[wa] <= wtag;
    if (rd_en) begin
      valid_rd_q <= valid_mem[q_set_i];
      tag_rd_q   <= tag_mem[q_set_i];
      rr_rd_q    <= rr_mem[q_set_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cur_tag_q <= q_tag_i;
      cur_set_q <= q_set_i;
    end
    rem_q <= rem_d;
    src_q <= src_d;
    way_q <= way_d;
    kind_q <= kind_d;
    hit_q <= hit_d;
    if (upd) begin
      out_hit_q  <= hit_q;
      out_kind_q <= kind_q;
      out_way_q  <= way_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      lfsr_q      <= sactl_pkg::LFSR_SEED;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      hits_q      <= '0;
      comp_q      <= '0;
      conf_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
      if (upd) begin
        if (acc_q != '1) acc_q <= acc_q + CNT_W'(1);
        if (hit_q && hits_q != '1) hits_q <= hits_q + CNT_W'(1);
        if (kind_q == sactl_pkg::KIND_COMPULSORY && comp_q != '1) comp_q <= comp_q + CNT_W'(1);
        if (kind_q == sactl_pkg::KIND_CONFLICT && conf_q != '1) conf_q <= conf_q + CNT_W'(1);
      end
    end
  end

  assign rsp.valid            = out_valid_q;
  assign rsp.hit              = out_hit_q;
  assign rsp.miss_kind        = out_kind_q;
  assign rsp.way_used         = sactl_pkg::WAY_OUT_W'(out_way_q);
  assign rsp.access_count     = acc_q;
  assign rsp.hit_count        = hits_q;
  assign rsp.compulsory_count = comp_q;
  assign rsp.conflict_count   = conf_q;

endmodule

>>> rtl/set_assoc_cache_tag_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Set-associative tag store with round-robin or pseudo-random replacement.
// ----------------------------------------------------------------------------
// channel | dir | word
// req_i   | in  | address
// cfg_i   | in  | index, data (0 offset_bits, 1 index_bits, 2 ways_in_use,
//         |     |  3 random_policy)
// rsp_o   | out | hit, miss_kind, way_used, access/hit/compulsory/conflict counts
//
// Hit or round-robin miss: each word passes the set read, compare and fill states;
// a random miss adds a remainder state for the LFSR word, 4 bits a cycle.
// After reset the back clears the valid bits and pointers, set by set,
// before the first lookup; the front queue may already take two words.
// The result register lets the next lookup run while a word waits on rsp_o.
module set_assoc_cache_tag_lookup #(
  parameter int unsigned MAX_SETS  = sactl_pkg::MAX_SETS,
  parameter int unsigned MAX_WAYS  = sactl_pkg::MAX_WAYS,
  parameter int unsigned ADDR_BITS = sactl_pkg::ADDR_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sactl_req_if.sink   req_i,
  sactl_cfg_if.sink   cfg_i,
  sactl_rsp_if.source rsp_o
);

  localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned ENT_W = ADDR_BITS + SET_W;

  sactl_pkg::cfg_t      cfg_q;
  logic                 push, full, pop, q_valid;
  logic [ADDR_BITS-1:0] tag;
  logic [SET_W-1:0]     set_num;
  logic [ENT_W-1:0]     q_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_bits   <= sactl_pkg::OFF_RST;
      cfg_q.index_bits    <= sactl_pkg::IDX_RST;
      cfg_q.ways_in_use   <= sactl_pkg::WAYS_RST;
      cfg_q.random_policy <= sactl_pkg::POLICY_RST;
    end else if (cfg_i.valid) begin
      unique case (sactl_pkg::cfg_reg_e'(cfg_i.index))
        sactl_pkg::REG_OFFSET: cfg_q.offset_bits   <= cfg_i.data[sactl_pkg::OFF_W-1:0];
        sactl_pkg::REG_INDEX:  cfg_q.index_bits    <= cfg_i.data[sactl_pkg::IDX_W-1:0];
        sactl_pkg::REG_WAYS:   cfg_q.ways_in_use   <= cfg_i.data[sactl_pkg::WAYS_CFG_W-1:0];
        sactl_pkg::REG_POLICY: cfg_q.random_policy <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  sactl_front #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_SETS  (MAX_SETS)
  ) u_front (
    .req      (req_i),
    .cfg_i    (cfg_q),
    .q_full_i (full),
    .push_o   (push),
    .tag_o    (tag),
    .set_o    (set_num)
  );

  sactl_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({tag, set_num}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  sactl_back #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_tag_i   (q_data[ENT_W-1:SET_W]),
    .q_set_i   (q_data[SET_W-1:0]),
    .pop_o     (pop),
    .rsp       (rsp_o)
  );

endmodule

>>> rtl/sactl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_checker
// Port-level checks on the result channel of the tag lookup.
// ----------------------------------------------------------------------------
module sactl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          hit,
  input logic [1:0]                    miss_kind,
  input logic [sactl_pkg::CNT_W-1:0]   access_count,
  input logic [sactl_pkg::CNT_W-1:0]   hit_count
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(access_count) && $stable(hit))
    else $error("result word dropped or changed while stalled");

  // hit flag and miss kind agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (hit && miss_kind == sactl_pkg::KIND_HIT) ||
                  (!hit && (miss_kind == sactl_pkg::KIND_COMPULSORY ||
                            miss_kind == sactl_pkg::KIND_CONFLICT)))
    else $error("hit flag and miss kind disagree");

  // hits never outnumber accesses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> hit_count <= access_count)
    else $error("hit count above access count");

  // a hit word carries nonzero hit and access counts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && hit |-> hit_count != '0 && access_count != '0)
    else $error("hit word with empty counts");

endmodule

bind set_assoc_cache_tag_lookup sactl_checker u_sactl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .hit          (rsp_o.hit),
  .miss_kind    (rsp_o.miss_kind),
  .access_count (rsp_o.access_count),
  .hit_count    (rsp_o.hit_count)
);
